// ===== src/mcc_pkg.sv =====
// Shared types, sizes and helpers for the minimum coin change block.
// Used by every module of the block but mcc_dpram; depends on nothing else.
`timescale 1ns / 1ps

package mcc_pkg;

  // Sizes of the table and the coin store
  localparam int MAX_TARGET = 64;
  localparam int MAX_COINS  = 32;
  localparam int INF_COUNT  = MAX_TARGET + 1;

  localparam int COIN_W  = 8;
  localparam int SUM_W   = $clog2(MAX_TARGET + 1);
  localparam int CNT_W   = $clog2(INF_COUNT + 1);
  localparam int IDX_W   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int NCOIN_W = $clog2(MAX_COINS + 1);

  // Input beat: one coin type
  typedef struct packed {
    logic [COIN_W-1:0] coin_value;
    logic              last_coin;
  } coin_in_t;

  // Output beat: one chosen coin or the impossible mark
  typedef struct packed {
    logic [COIN_W-1:0] chosen_coin;
    logic              solvable;
    logic [6:0]        coin_total;
    logic              last_result;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // take the coin beat, store it, arm the table sweep
    logic upd_run;     // advance the table sweep by one sum
    logic walk_init;   // restart the walk at the last coin and the target
    logic cnt_clr;     // zero the coin count of the solution
    logic walk_issue;  // fetch the current coin and read its two table entries
    logic walk_eval;   // take the coin or step to the previous coin type
    logic walk_count;  // count taken coins
    logic emit_take;   // put a taken coin on the result port
    logic emit_fail;   // put the impossible mark on the result port
    logic clear;       // empty the table and the coin store
  } mcc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic upd_done;    // table sweep finished, last write committed
    logic last;        // held coin closes the set
    logic tgt_ok;      // target lies in 1..MAX_TARGET
    logic j_zero;      // remaining sum is zero
    logic i_zero;      // no coin types left to try
    logic take;        // current coin lies on an optimal path
    logic tj_inf;      // remaining sum is unreachable
  } mcc_stat_t;

  // Add one coin, saturating at infinity
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    if (v >= CNT_W'(INF_COUNT)) begin
      return CNT_W'(INF_COUNT);
    end
    return v + CNT_W'(1);
  endfunction

endpackage

// ===== src/min_coin_change_dp.sv =====
// Minimum coin change: one coin type per beat folded into a minimum-count table
// over sums 0..MAX_TARGET, then a walk-back that emits the chosen coins.
// Coin beat: for values 1..64 busy spans a sweep of sums coin_value..MAX_TARGET (one sum
// per cycle), with no sweep otherwise or when full; the next beat is taken in the first
// cycle with busy low. Closing coin: two read/evaluate walks (count, emit) or failure;
// result beats never back to back or stalled. Reset: target 0, table empty, no sweep.
`timescale 1ns / 1ps

module min_coin_change_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic              start,
  input  mcc_pkg::coin_in_t coin_in,
  output logic              busy,
  output logic              result_valid,
  output mcc_pkg::result_t  result
);

  mcc_pkg::mcc_cmd_t  cmd;
  mcc_pkg::mcc_stat_t stat;

  mcc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mcc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .coin_in      (coin_in),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== src/mcc_dpram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mcc_dpram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] qa,
  output logic [WIDTH-1:0] qb
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

endmodule

// ===== src/mcc_datapath.sv =====
// Datapath: target register, coin store, minimum-count table with valid bits,
// table sweep, walk-back registers and the result register.
// Depends on mcc_pkg and mcc_dpram.
`timescale 1ns / 1ps

module mcc_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [6:0]                cfg_wdata,
  input  mcc_pkg::coin_in_t         coin_in,
  input  mcc_pkg::mcc_cmd_t         cmd,
  output mcc_pkg::mcc_stat_t        stat,
  output logic                      result_valid,
  output mcc_pkg::result_t          result
);

  localparam int SW = mcc_pkg::SUM_W;
  localparam int CW = mcc_pkg::CNT_W;
  localparam int VW = mcc_pkg::COIN_W;
  localparam int NW = mcc_pkg::NCOIN_W;
  localparam int IW = mcc_pkg::IDX_W;

  // Configuration and coin store
  logic [SW-1:0] target_sum;
  logic [VW-1:0] coin_store [mcc_pkg::MAX_COINS];
  logic [NW-1:0] coin_count;
  logic [VW-1:0] coin_val;
  logic          last_flag;

  // Table sweep
  logic          upd_act;
  logic [SW-1:0] s;
  logic          p_vld;
  logic [SW-1:0] p_s;
  logic [mcc_pkg::MAX_TARGET:0] tvld;

  // Read side of the table
  logic [SW-1:0] rd_a, rd_b;
  logic [CW-1:0] qa, qb;
  logic          fwd_a, fwd_b, zero_a, zero_b, vld_a, vld_b;
  logic [CW-1:0] fwd_data;
  logic [CW-1:0] ta, tb;

  // Write side of the table
  logic          we;
  logic [CW-1:0] cand;

  // Walk-back
  logic [NW-1:0] walk_i;
  logic [SW-1:0] walk_j;
  logic [VW-1:0] walk_c;
  logic          walk_okc;
  logic [NW-1:0] walk_im1;
  logic [VW-1:0] cur_c;
  logic          cur_okc;
  logic [SW-1:0] walk_ja;
  logic [SW-1:0] n_count;
  logic          take;

  logic room;

  assign room = coin_count < NW'(mcc_pkg::MAX_COINS);

  // Target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_we) begin
      target_sum <= SW'(cfg_wdata);
    end
  end

  // Latch the coin beat and store it while there is room
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coin_val  <= coin_in.coin_value;
      last_flag <= coin_in.last_coin;
      if (room) begin
        coin_store[coin_count[IW-1:0]] <= coin_in.coin_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      coin_count <= '0;
    end else if (cmd.load && room) begin
      coin_count <= coin_count + NW'(1);
    end
  end

  // Sweep the sums from the coin value up to the top of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_act <= 1'b0;
      p_vld   <= 1'b0;
    end else if (cmd.load) begin
      upd_act <= room && (coin_in.coin_value != '0) &&
                 (int'(coin_in.coin_value) <= mcc_pkg::MAX_TARGET);
      p_vld   <= 1'b0;
    end else if (cmd.upd_run) begin
      p_vld <= upd_act;
      if (upd_act && (s == SW'(mcc_pkg::MAX_TARGET))) begin
        upd_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s <= SW'(coin_in.coin_value);
    end else if (cmd.upd_run && upd_act) begin
      p_s <= s;
      if (s != SW'(mcc_pkg::MAX_TARGET)) begin
        s <= s + SW'(1);
      end
    end
  end

  // Relax one entry: one more coin than the sum below, if that is better
  assign cand = mcc_pkg::sat_inc(ta);
  assign we   = cmd.upd_run && p_vld && (cand < tb);

  // Valid bits: an entry never written reads as infinity
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      tvld <= '0;
    end else if (we) begin
      tvld[p_s] <= 1'b1;
    end
  end

  // Current coin of the walk and its two table addresses
  assign walk_im1 = walk_i - NW'(1);
  assign cur_c    = coin_store[walk_im1[IW-1:0]];
  assign cur_okc  = (cur_c != '0) && (int'(cur_c) <= int'(walk_j));
  assign walk_ja  = cur_okc ? (walk_j - SW'(cur_c)) : walk_j;

  assign rd_a = cmd.walk_issue ? walk_ja : (s - SW'(coin_val));
  assign rd_b = cmd.walk_issue ? walk_j  : s;

  mcc_dpram #(
    .WIDTH (CW),
    .DEPTH (mcc_pkg::MAX_TARGET + 1),
    .AW    (SW)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (p_s),
    .wdata   (cand),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .qa      (qa),
    .qb      (qb)
  );

  // Capture read qualifiers next to the RAM read data
  always_ff @(posedge clk) begin
    zero_a   <= (rd_a == '0);
    zero_b   <= (rd_b == '0);
    vld_a    <= (int'(rd_a) <= mcc_pkg::MAX_TARGET) ? tvld[rd_a] : 1'b0;
    vld_b    <= (int'(rd_b) <= mcc_pkg::MAX_TARGET) ? tvld[rd_b] : 1'b0;
    fwd_a    <= we && (p_s == rd_a);
    fwd_b    <= we && (p_s == rd_b);
    fwd_data <= cand;
  end

  // Effective table values: bypass, entry zero, stored, unwritten
  always_comb begin
    if (fwd_a) begin
      ta = fwd_data;
    end else if (zero_a) begin
      ta = '0;
    end else if (vld_a) begin
      ta = qa;
    end else begin
      ta = CW'(mcc_pkg::INF_COUNT);
    end
    if (fwd_b) begin
      tb = fwd_data;
    end else if (zero_b) begin
      tb = '0;
    end else if (vld_b) begin
      tb = qb;
    end else begin
      tb = CW'(mcc_pkg::INF_COUNT);
    end
  end

  assign take = walk_okc && (tb == mcc_pkg::sat_inc(ta));

  // Walk-back registers
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_i <= coin_count;
      walk_j <= target_sum;
    end else if (cmd.walk_eval) begin
      if (take) begin
        walk_j <= walk_j - SW'(walk_c);
      end else begin
        walk_i <= walk_im1;
      end
    end
    if (cmd.walk_issue) begin
      walk_c   <= cur_c;
      walk_okc <= cur_okc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      n_count <= '0;
    end else if (cmd.walk_count && take) begin
      n_count <= n_count + SW'(1);
    end
  end

  // Result register; result_valid is high for a single cycle per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit_take && take) || cmd.emit_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fail) begin
      result.chosen_coin <= '0;
      result.solvable    <= 1'b0;
      result.coin_total  <= '0;
      result.last_result <= 1'b1;
    end else if (cmd.emit_take) begin
      result.chosen_coin <= walk_c;
      result.solvable    <= 1'b1;
      result.coin_total  <= 7'(n_count);
      result.last_result <= (walk_j == SW'(walk_c));
    end
  end

  // Status
  assign stat.upd_done = !upd_act && !p_vld;
  assign stat.last     = last_flag;
  assign stat.tgt_ok   = (target_sum != '0) &&
                         (int'(target_sum) <= mcc_pkg::MAX_TARGET);
  assign stat.j_zero   = (walk_j == '0);
  assign stat.i_zero   = (walk_i == '0);
  assign stat.take     = take;
  assign stat.tj_inf   = (tb == CW'(mcc_pkg::INF_COUNT));

endmodule

// ===== src/mcc_ctrl.sv =====
// Controller: sequences the table sweep, the counting walk, the emitting walk
// and the clearing of the set. Depends on mcc_pkg.
`timescale 1ns / 1ps

module mcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mcc_pkg::mcc_stat_t stat,
  output mcc_pkg::mcc_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_UPD   = 7'b0000010,
    S_W1_RD = 7'b0000100,
    S_W1_EV = 7'b0001000,
    S_W2_RD = 7'b0010000,
    S_W2_EV = 7'b0100000,
    S_FAIL  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_run = 1'b1;
        if (stat.upd_done) begin
          if (!stat.last) begin
            state_next = S_IDLE;
          end else if (!stat.tgt_ok) begin
            state_next = S_FAIL;
          end else begin
            cmd.walk_init = 1'b1;
            cmd.cnt_clr   = 1'b1;
            state_next    = S_W1_RD;
          end
        end
      end
      // First walk: count the coins and check that the walk pays the sum
      S_W1_RD: begin
        if (stat.j_zero) begin
          cmd.walk_init = 1'b1;
          state_next    = S_W2_RD;
        end else if (stat.i_zero) begin
          state_next = S_FAIL;
        end else begin
          cmd.walk_issue = 1'b1;
          state_next     = S_W1_EV;
        end
      end
      S_W1_EV: begin
        if (stat.tj_inf) begin
          state_next = S_FAIL;
        end else begin
          cmd.walk_eval  = 1'b1;
          cmd.walk_count = 1'b1;
          state_next     = S_W1_RD;
        end
      end
      // Second walk: replay the same path and emit each coin taken
      S_W2_RD: begin
        if (stat.j_zero) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.i_zero) begin
          state_next = S_FAIL;
        end else begin
          cmd.walk_issue = 1'b1;
          state_next     = S_W2_EV;
        end
      end
      S_W2_EV: begin
        cmd.walk_eval = 1'b1;
        cmd.emit_take = 1'b1;
        state_next    = S_W2_RD;
      end
      S_FAIL: begin
        cmd.emit_fail = 1'b1;
        cmd.clear     = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/mcc_checker.sv =====
// Port-level checks on the minimum coin change block, bound to its top level.
// Depends on mcc_pkg and min_coin_change_dp.
`timescale 1ns / 1ps

module mcc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input mcc_pkg::result_t  result
);

  // An accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted coin beat");

  // Result beats never come back to back
  a_res_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result beats in consecutive cycles");

  // The impossible mark is a final beat with a zero coin and a zero total
  a_fail_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.solvable) |->
      (result.last_result && (result.chosen_coin == '0) && (result.coin_total == '0)))
    else $error("malformed impossible result");

  // A paid result carries a real coin and a nonzero total
  a_take_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.solvable) |->
      ((result.chosen_coin != '0) && (result.coin_total != '0)))
    else $error("malformed coin result");

  // The total holds across the beats of one run
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.solvable && !result.last_result) |=>
      ##1 (!result_valid || (result.coin_total == $past(result.coin_total, 2))))
    else $error("coin total changed within a run");

endmodule

bind min_coin_change_dp mcc_checker u_mcc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
